@@ sv/hfs_pkg.sv @@
// Shared constants, types and a byte-class function for the HTTP field scanner.
package hfs_pkg;

  localparam int unsigned PosW = 32;

  // Scan modes.
  localparam logic [1:0] MODE_HDR_END = 2'd0;
  localparam logic [1:0] MODE_HDR_VAL = 2'd1;
  localparam logic [1:0] MODE_URI     = 2'd2;
  localparam logic [1:0] MODE_HDR_NAM = 2'd3;

  // Result outcomes.
  localparam logic [1:0] OUT_FOUND  = 2'd0;
  localparam logic [1:0] OUT_REJECT = 2'd1;
  localparam logic [1:0] OUT_END    = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SCAN_MODE = 1'b0;
  localparam logic CFG_START_POS = 1'b1;

  // Characters.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_VIS   = 8'h21;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    logic            emit;
    logic [1:0]      outcome;
    logic [PosW-1:0] found;
    logic [PosW-1:0] canon;
  } result_t;

  // RFC 9110 token character.
  function automatic logic is_tchar(input logic [7:0] b);
    logic r;
    r = 1'b0;
    if (b >= 8'h30 && b <= 8'h39) r = 1'b1;
    if (b >= 8'h41 && b <= 8'h5A) r = 1'b1;
    if (b >= 8'h61 && b <= 8'h7A) r = 1'b1;
    unique case (b)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

endpackage

@@ sv/hfs_in_stage.sv @@
// Input register stage of the HTTP field scanner.
module hfs_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  hfs_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          stall_o,
  output logic          valid_o,
  output hfs_pkg::item_t item_o
);
  import hfs_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // The register takes a new request when empty or when its content moves on.
  assign stall_o = valid_q & ~advance_i;
  assign load    = valid_i & ~stall_o;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) valid_d = 1'b0;
    if (load) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

@@ sv/hfs_scan_core.sv @@
// Scan state and per-byte decision logic of the HTTP field scanner.
module hfs_scan_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  hfs_pkg::item_t           item_i,
  input  logic [1:0]               mode_i,
  input  logic [hfs_pkg::PosW-1:0] start_pos_i,
  output hfs_pkg::result_t         result_o,
  output logic                     done_o
);
  import hfs_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, qoff_q, qoff_d;
  logic [23:0]     recent_q, recent_d;
  logic            qseen_q, qseen_d, done_q, done_d;

  logic [PosW-1:0] pos_e, qoff_e, here, endpos;
  logic [23:0]     recent_e;
  logic            qseen_e, active;
  logic [7:0]      b;
  result_t         res;

  always_comb begin
    b        = item_i.data;
    pos_e    = item_i.first ? start_pos_i : pos_q;
    recent_e = item_i.first ? 24'd0 : recent_q;
    qoff_e   = item_i.first ? '0 : qoff_q;
    qseen_e  = item_i.first ? 1'b0 : qseen_q;
    active   = fire_i & (item_i.first | ~done_q);
    here     = pos_e;
    endpos   = pos_e + PosW'(1);

    res      = '0;
    recent_d = recent_e;
    qoff_d   = qoff_e;
    qseen_d  = qseen_e;

    unique case (mode_i)
      MODE_HDR_END: begin
        recent_d = {recent_e[15:0], b};
        if (b == CH_LF && recent_e == {CH_CR, CH_LF, CH_CR}) begin
          res.emit = 1'b1; res.outcome = OUT_FOUND; res.found = endpos;
        end else if (item_i.last) begin
          res.emit = 1'b1; res.outcome = OUT_END;
        end
      end
      MODE_HDR_VAL: begin
        if (b == CH_CR) begin
          res.emit = 1'b1; res.outcome = OUT_FOUND; res.found = here;
        end else if ((b < CH_SP && b != CH_TAB) || b == CH_DEL) begin
          res.emit = 1'b1; res.outcome = OUT_REJECT;
        end else if (item_i.last) begin
          res.emit = 1'b1; res.outcome = OUT_END; res.found = endpos;
        end
      end
      MODE_URI: begin
        if (b == CH_SP) begin
          res.emit = 1'b1; res.outcome = OUT_FOUND; res.found = here;
          res.canon = qseen_e ? qoff_e : here;
        end else if (b < CH_VIS || b >= CH_DEL) begin
          res.emit = 1'b1; res.outcome = OUT_REJECT;
        end else begin
          if ((b == CH_QM || b == CH_HASH) && !qseen_e) begin
            qseen_d = 1'b1;
            qoff_d  = here;
          end
          if (item_i.last) begin
            res.emit = 1'b1; res.outcome = OUT_END; res.found = endpos;
            res.canon = qseen_d ? qoff_d : endpos;
          end
        end
      end
      MODE_HDR_NAM: begin
        if (b == CH_COLON) begin
          res.emit = 1'b1; res.outcome = OUT_FOUND; res.found = here;
        end else if (!is_tchar(b) || item_i.last) begin
          res.emit = 1'b1; res.outcome = OUT_REJECT;
        end
      end
      default: ;
    endcase

    res.emit &= active;
    pos_d  = endpos;
    done_d = res.emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      recent_q <= '0;
      qoff_q   <= '0;
      qseen_q  <= 1'b0;
      done_q   <= 1'b1;
    end else if (active) begin
      pos_q    <= pos_d;
      recent_q <= recent_d;
      qoff_q   <= qoff_d;
      qseen_q  <= qseen_d;
      done_q   <= done_d;
    end
  end

  assign result_o = res;
  assign done_o   = done_q;
endmodule

@@ sv/http_field_scanner.sv @@
// Top level of the HTTP field scanner: config registers, pipeline and result register.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-----------------------------------------
//  in      | in_valid_i | in_stall_o  | data_byte_i, first_byte_i, last_byte_i
//  out     | out_valid_o| out_stall_i | outcome_o, found_position_o, canonical_end_o
//  config  | cfg_we_i   | (none)      | cfg_index_i, cfg_wdata_i
//
// Each request sits in the input register while the scan logic decides it combinationally,
// and the result register loads its result when the pipeline advances; one byte is taken
// every cycle while the result register is not held by out_stall_i.
// The result register is the only place a finished result waits. While it is held by
// out_stall_i, the input register keeps its byte and asserts in_stall_o once full.
// Reset clears the scan state to idle: bytes without first_byte are dropped until a scan
// is opened. Configuration registers reset to header-end mode and start offset zero.
module http_field_scanner (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [hfs_pkg::PosW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     first_byte_i,
  input  logic                     last_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               outcome_o,
  output logic [hfs_pkg::PosW-1:0] found_position_o,
  output logic [hfs_pkg::PosW-1:0] canonical_end_o
);
  import hfs_pkg::*;

  // Configuration registers.
  logic [1:0]      mode_q;
  logic [PosW-1:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HDR_END;
      start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCAN_MODE: mode_q  <= cfg_wdata_i[1:0];
        CFG_START_POS: start_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the result register is free or being emptied.
  logic    advance, stage_valid, fire, core_done;
  item_t   in_item, stage_item;
  result_t core_res;

  assign advance = ~out_valid_o | ~out_stall_i;
  assign fire    = advance & stage_valid;
  assign in_item = '{data: data_byte_i, first: first_byte_i, last: last_byte_i};

  hfs_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .item_i    (in_item),
    .advance_i (advance),
    .stall_o   (in_stall_o),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  hfs_scan_core u_scan_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (stage_item),
    .mode_i      (mode_q),
    .start_pos_i (start_q),
    .result_o    (core_res),
    .done_o      (core_done)
  );

  // Result register: its valid bit loads on every advance and is set only if the byte produced a result.
  logic            out_valid_q, out_valid_d;
  logic [1:0]      outcome_q;
  logic [PosW-1:0] found_q, canon_q;

  assign out_valid_d = advance ? core_res.emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_res.emit) begin
      outcome_q <= core_res.outcome;
      found_q   <= core_res.found;
      canon_q   <= core_res.canon;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign found_position_o = found_q;
  assign canonical_end_o  = canon_q;

  // A rejected scan never reports a position.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OUT_REJECT |-> found_position_o == '0 && canonical_end_o == '0)
    else $error("rejected result carries a position");

  // The input side only stalls while a result is held in the result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // Once a result is produced the scan goes idle.
  a_done_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && core_res.emit |=> core_done)
    else $error("scan not idle after result");

  // The outcome code three never appears.
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outcome_o == OUT_FOUND || outcome_o == OUT_REJECT || outcome_o == OUT_END)
    else $error("illegal outcome code");

endmodule
